// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define GNS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GNS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/gns_pkg.sv =====
package gns_pkg;

  localparam int PIXEL_W = 16;
  localparam int SUM_W = PIXEL_W + 3;
  localparam int POS_W = 5;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int MAX_WIDTH = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int WIDTH_RESET = 5;
  localparam int HEIGHT_RESET = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(1);

  typedef logic signed [PIXEL_W-1:0] pixel_t;
  typedef logic signed [PIXEL_W:0] col2_t;
  typedef logic signed [PIXEL_W+1:0] col3_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [POS_W-1:0] pos_t;

  // One window position handed from the front end to the back end. Column 2 is the
  // current column, column 0 the oldest. full sums rows r-2..r, part sums rows r-1..r.
  typedef struct packed {
    pos_t row;
    pos_t col;
    logic has_up;
    logic has_left;
    logic last_row;
    logic last_col;
    col3_t full0;
    col3_t full1;
    col3_t full2;
    col2_t part0;
    col2_t part1;
    col2_t part2;
    pixel_t mid1;
    pixel_t mid2;
    pixel_t cur1;
    pixel_t cur2;
  } desc_t;

endpackage

// ===== sv/gns_front.sv =====
module gns_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gns_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gns_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                pixel_valid,
  input  gns_pkg::pixel_t                     pixel,
  output logic                                pixel_stall,
  input  logic                                room,
  output logic                                push,
  output gns_pkg::desc_t                      push_desc
);

  localparam int ADDR_W = $clog2(3 * gns_pkg::MAX_WIDTH);
  localparam int DIM_W = gns_pkg::CFG_DATA_W + 1;

  function automatic gns_pkg::pos_t dim_m1(input logic [gns_pkg::CFG_DATA_W-1:0] value,
                                           input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] d;
    d = {1'b0, value};
    if (d == '0) d = DIM_W'(1);
    if (d > max_dim) d = max_dim;
    return gns_pkg::pos_t'(d - DIM_W'(1));
  endfunction

  gns_pkg::pos_t width_m1;
  gns_pkg::pos_t height_m1;
  gns_pkg::pos_t in_row;
  gns_pkg::pos_t in_col;
  logic [1:0] slot;
  logic [1:0] slot_up1;
  logic [1:0] slot_up2;
  logic accept;
  logic last_row_now;
  logic last_col_now;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] up1_addr;
  logic [ADDR_W-1:0] up2_addr;

  gns_pkg::pixel_t line_mem [0:3*gns_pkg::MAX_WIDTH-1];

  logic s1_valid;
  gns_pkg::pixel_t s1_pixel;
  gns_pkg::pixel_t s1_up1;
  gns_pkg::pixel_t s1_up2;
  gns_pkg::pos_t s1_row;
  gns_pkg::pos_t s1_col;
  logic s1_has_up;
  logic s1_has_up2;
  logic s1_has_left;
  logic s1_has_left2;
  logic s1_last_row;
  logic s1_last_col;

  gns_pkg::col3_t prev1_full;
  gns_pkg::col2_t prev1_part;
  gns_pkg::pixel_t prev1_mid;
  gns_pkg::pixel_t prev1_cur;
  gns_pkg::col3_t prev2_full;
  gns_pkg::col2_t prev2_part;

  gns_pkg::pixel_t up1_masked;
  gns_pkg::pixel_t up2_masked;
  gns_pkg::col3_t new_full;
  gns_pkg::col2_t new_part;

  assign pixel_stall = !room;
  assign accept = pixel_valid && room;
  assign last_row_now = (in_row == height_m1);
  assign last_col_now = (in_col == width_m1);

  always_comb begin
    slot_up1 = (slot == 2'd0) ? 2'd2 : slot - 2'd1;
    slot_up2 = (slot == 2'd2) ? 2'd0 : slot + 2'd1;
  end

  assign wr_addr = ADDR_W'(int'(slot) * gns_pkg::MAX_WIDTH + int'(in_col));
  assign up1_addr = ADDR_W'(int'(slot_up1) * gns_pkg::MAX_WIDTH + int'(in_col));
  assign up2_addr = ADDR_W'(int'(slot_up2) * gns_pkg::MAX_WIDTH + int'(in_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      width_m1 <= gns_pkg::pos_t'(gns_pkg::WIDTH_RESET - 1);
      height_m1 <= gns_pkg::pos_t'(gns_pkg::HEIGHT_RESET - 1);
      in_row <= '0;
      in_col <= '0;
      slot <= 2'd0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_write) begin
        unique case (cfg_index)
          gns_pkg::REG_FRAME_WIDTH: begin
            width_m1 <= dim_m1(cfg_data, DIM_W'(gns_pkg::MAX_WIDTH));
            in_row <= '0;
            in_col <= '0;
            slot <= 2'd0;
          end
          gns_pkg::REG_FRAME_HEIGHT: begin
            height_m1 <= dim_m1(cfg_data, DIM_W'(gns_pkg::MAX_HEIGHT));
            in_row <= '0;
            in_col <= '0;
            slot <= 2'd0;
          end
          default: begin
          end
        endcase
      end else if (accept) begin
        if (last_col_now) begin
          in_col <= '0;
          if (last_row_now) begin
            in_row <= '0;
            slot <= 2'd0;
          end else begin
            in_row <= in_row + gns_pkg::pos_t'(1);
            slot <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
          end
        end else begin
          in_col <= in_col + gns_pkg::pos_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[wr_addr] <= pixel;
      s1_up1 <= line_mem[up1_addr];
      s1_up2 <= line_mem[up2_addr];
      s1_pixel <= pixel;
      s1_row <= in_row;
      s1_col <= in_col;
      s1_has_up <= (in_row != '0);
      s1_has_up2 <= (in_row > gns_pkg::pos_t'(1));
      s1_has_left <= (in_col != '0);
      s1_has_left2 <= (in_col > gns_pkg::pos_t'(1));
      s1_last_row <= last_row_now;
      s1_last_col <= last_col_now;
    end
  end

  always_comb begin
    up1_masked = s1_has_up ? s1_up1 : '0;
    up2_masked = s1_has_up2 ? s1_up2 : '0;
    new_full = gns_pkg::col3_t'(up2_masked) + gns_pkg::col3_t'(up1_masked)
             + gns_pkg::col3_t'(s1_pixel);
    new_part = gns_pkg::col2_t'(up1_masked) + gns_pkg::col2_t'(s1_pixel);
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prev2_full <= prev1_full;
      prev2_part <= prev1_part;
      prev1_full <= new_full;
      prev1_part <= new_part;
      prev1_mid <= up1_masked;
      prev1_cur <= s1_pixel;
    end
  end

  // Columns left of the frame edge hold the previous row's tail and are masked.
  always_comb begin
    push = s1_valid && (s1_has_up || s1_last_row) && (s1_has_left || s1_last_col);
    push_desc.row = s1_row;
    push_desc.col = s1_col;
    push_desc.has_up = s1_has_up;
    push_desc.has_left = s1_has_left;
    push_desc.last_row = s1_last_row;
    push_desc.last_col = s1_last_col;
    push_desc.full0 = s1_has_left2 ? prev2_full : '0;
    push_desc.part0 = s1_has_left2 ? prev2_part : '0;
    push_desc.full1 = s1_has_left ? prev1_full : '0;
    push_desc.part1 = s1_has_left ? prev1_part : '0;
    push_desc.full2 = new_full;
    push_desc.part2 = new_part;
    push_desc.mid1 = prev1_mid;
    push_desc.cur1 = prev1_cur;
    push_desc.mid2 = up1_masked;
    push_desc.cur2 = s1_pixel;
  end

endmodule

// ===== sv/gns_queue.sv =====
module gns_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gns_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output gns_pkg::desc_t head_desc,
  output logic           room
);

  localparam int PTR_W = $clog2(gns_pkg::QUEUE_DEPTH);

  gns_pkg::desc_t entries [gns_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0] count;

  assign head_valid = (count != '0);
  assign head_desc = entries[rd_ptr];
  // Two free entries cover the item still held in the front end's s1 register.
  assign room = (count <= (PTR_W + 1)'(gns_pkg::QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10: count <= count + (PTR_W + 1)'(1);
        2'b01: count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_desc;
  end

endmodule

// ===== sv/gns_back.sv =====
module gns_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  gns_pkg::desc_t head_desc,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_stall,
  output gns_pkg::sum_t  neighbour_sum,
  output gns_pkg::pos_t  cell_row,
  output gns_pkg::pos_t  cell_col,
  output logic           frame_end
);

  logic row_step;
  logic col_step;
  logic load;
  logic dr;
  logic dc;
  logic row_done;
  logic col_done;
  gns_pkg::sum_t term0;
  gns_pkg::sum_t term1;
  gns_pkg::sum_t term2;
  gns_pkg::sum_t center;
  gns_pkg::sum_t sum_next;

  assign load = head_valid && (!result_valid || !result_stall);
  assign dr = head_desc.has_up && !row_step;
  assign dc = head_desc.has_left && !col_step;
  assign col_done = col_step || !(head_desc.has_left && head_desc.last_col);
  assign row_done = row_step || !(head_desc.has_up && head_desc.last_row);
  assign pop = load && col_done && row_done;

  // The cell sits one row up when dr is set and one column left when dc is set.
  always_comb begin
    if (dc) begin
      term0 = dr ? gns_pkg::sum_t'(head_desc.full0) : gns_pkg::sum_t'(head_desc.part0);
      center = dr ? gns_pkg::sum_t'(head_desc.mid1) : gns_pkg::sum_t'(head_desc.cur1);
    end else begin
      term0 = '0;
      center = dr ? gns_pkg::sum_t'(head_desc.mid2) : gns_pkg::sum_t'(head_desc.cur2);
    end
    term1 = dr ? gns_pkg::sum_t'(head_desc.full1) : gns_pkg::sum_t'(head_desc.part1);
    term2 = dr ? gns_pkg::sum_t'(head_desc.full2) : gns_pkg::sum_t'(head_desc.part2);
    sum_next = term0 + term1 + term2 - center;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      row_step <= 1'b0;
      col_step <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        if (col_done) begin
          col_step <= 1'b0;
          row_step <= !row_done;
        end else begin
          col_step <= 1'b1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neighbour_sum <= sum_next;
      cell_row <= head_desc.row - gns_pkg::pos_t'(dr);
      cell_col <= head_desc.col - gns_pkg::pos_t'(dc);
      frame_end <= !dr && !dc;
    end
  end

endmodule

// ===== sv/grid_neighbour_sum.sv =====
// Eight-neighbour sum over a 3x3 window. Pixels enter in raster order at up to one per
// cycle unless stalled; each result gives the sum of a cell's in-frame neighbours with
// its row and column, and frame_end marks the frame's last cell. A pixel's window beat
// is pushed into a four-entry queue in the cycle after the pixel is taken, and its first
// result is registered from the queue head. The back end emits one result per cycle
// unless stalled. Most pixels yield one result; pixels of the first row or the first
// column yield none unless that row or column is also the last, a pixel in the last
// column or the last row yields two, and the last pixel of a frame up to four. So
// pixel_stall rises while the queue holds more than two beats, and the input rate over
// a frame is set by that single result per cycle. Writing either dimension restarts the
// frame; dimensions of zero are taken as one and values above 32 as 32.
module grid_neighbour_sum (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gns_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [gns_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  gns_pkg::pixel_t                  pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output gns_pkg::sum_t                    neighbour_sum,
  output gns_pkg::pos_t                    cell_row,
  output gns_pkg::pos_t                    cell_col,
  output logic                             frame_end
);

  logic room;
  logic push;
  logic pop;
  logic head_valid;
  gns_pkg::desc_t push_desc;
  gns_pkg::desc_t head_desc;

  gns_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .pixel_stall (pixel_stall),
    .room        (room),
    .push        (push),
    .push_desc   (push_desc)
  );

  gns_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .room       (room)
  );

  gns_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_desc     (head_desc),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .neighbour_sum (neighbour_sum),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .frame_end     (frame_end)
  );

endmodule

// ===== sv/gns_checker.sv =====
`include "assert_macros.svh"

module gns_checker (
  input logic          clk,
  input logic          rst,
  input logic          pixel_stall,
  input logic          result_valid,
  input logic          result_stall,
  input gns_pkg::sum_t neighbour_sum,
  input gns_pkg::pos_t cell_row,
  input gns_pkg::pos_t cell_col,
  input logic          frame_end
);

  localparam gns_pkg::sum_t SumHigh = gns_pkg::sum_t'(8 * (2 ** (gns_pkg::PIXEL_W - 1) - 1));

  `GNS_ASSERT_ALWAYS(a_reset_clears, rst |=> !result_valid && !pixel_stall, "reset left a result or a stall")
  `GNS_ASSERT(a_valid_holds, result_valid && result_stall |=> result_valid, "result dropped while stalled")
  `GNS_ASSERT(a_payload_holds, result_valid && result_stall |=> $stable(neighbour_sum) && $stable(cell_row) && $stable(cell_col) && $stable(frame_end), "result changed while stalled")
  `GNS_ASSERT(a_sum_range, result_valid |-> neighbour_sum <= SumHigh, "sum above the largest eight-pixel total")

endmodule

bind grid_neighbour_sum gns_checker u_gns_checker (
  .clk           (clk),
  .rst           (rst),
  .pixel_stall   (pixel_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .neighbour_sum (neighbour_sum),
  .cell_row      (cell_row),
  .cell_col      (cell_col),
  .frame_end     (frame_end)
);
